// ----- hdl/sar_pkg.sv -----
// shared types, constants and float32 helper functions for the saturation rate pipeline
package sar_pkg;

  localparam logic [31:0] F_QNAN    = 32'h7FC0_0000;
  localparam logic [31:0] F_ONE     = 32'h3F80_0000;
  localparam logic [31:0] F_ZERO    = 32'h0000_0000;
  localparam logic [31:0] SIGN_MASK = 32'h8000_0000;

  localparam int unsigned MUL_LAT    = 3;
  localparam int unsigned ADD_LAT    = 5;
  localparam int unsigned DIV_STAGES = 13;
  localparam int unsigned DIV_BITS   = 2;
  localparam int unsigned DIV_QBITS  = DIV_STAGES * DIV_BITS;
  localparam int unsigned DIV_LAT    = DIV_STAGES + 2;

  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RV   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QMIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DT   = 2'd2;
  localparam logic [CFG_W-1:0] RV_RST   = 32'h43E6_C000;
  localparam logic [CFG_W-1:0] QMIN_RST = 32'h2690_FE7D;
  localparam logic [CFG_W-1:0] DT_RST   = 32'h3F80_0000;

  // unpacked operand, mantissa normalized with the leading one at bit 23
  typedef struct packed {
    logic               sign;
    logic signed [11:0] exp;
    logic [23:0]        man;
    logic               zero;
    logic               inf;
    logic               nan;
  } fp_unp_t;

  // sign, exponent and special-case flags that ride along a datapath
  typedef struct packed {
    logic               sign;
    logic signed [11:0] exp;
    logic               nan;
    logic               inf;
    logic               zero;
  } fp_side_t;

  function automatic fp_unp_t fp_unpack(input logic [31:0] f);
    fp_unp_t    u;
    logic [4:0] lz;
    logic       found;
    lz    = '0;
    found = 1'b0;
    for (int i = 22; i >= 0; i--) begin
      if (!found) begin
        if (f[i]) found = 1'b1;
        else lz = lz + 5'd1;
      end
    end
    u.sign = f[31];
    u.nan  = (f[30:23] == 8'hFF) && (f[22:0] != '0);
    u.inf  = (f[30:23] == 8'hFF) && (f[22:0] == '0);
    u.zero = (f[30:0] == '0);
    if (f[30:23] != '0) begin
      u.exp = $signed({4'b0, f[30:23]});
      u.man = {1'b1, f[22:0]};
    end else begin
      // subnormal: shift the leading one up, exponent goes to zero or below
      u.exp = -$signed({7'b0, lz});
      u.man = {f[22:0], 1'b0} << lz;
    end
    return u;
  endfunction

  // m[26] is the leading one, m[2] guard, m[1:0] round and sticky
  function automatic logic [31:0] fp_round_pack(input logic sign, input logic signed [11:0] e,
                                                input logic [26:0] m);
    logic signed [12:0] t;
    logic [4:0]         sh;
    logic [26:0]        mask;
    logic [26:0]        m2;
    logic               inc;
    logic [24:0]        r;
    logic signed [11:0] e1;
    logic [31:0]        y;
    t    = '0;
    sh   = '0;
    mask = '0;
    m2   = m;
    inc  = 1'b0;
    r    = '0;
    e1   = e;
    y    = '0;
    if (e >= 12'sd255) begin
      y = {sign, 8'hFF, 23'b0};
    end else if (e < 12'sd1) begin
      // subnormal result: denormalize with sticky, then round
      t    = 13'sd1 - 13'(e);
      sh   = (t > 13'sd27) ? 5'd27 : t[4:0];
      mask = ~({27{1'b1}} << sh);
      m2   = m >> sh;
      m2[0] = m2[0] | (|(m & mask));
      inc  = m2[2] & ((|m2[1:0]) | m2[3]);
      r    = {1'b0, m2[26:3]} + 25'(inc);
      y    = {sign, 7'b0, r[23], r[22:0]};
    end else begin
      inc = m[2] & ((|m[1:0]) | m[3]);
      r   = {1'b0, m[26:3]} + 25'(inc);
      if (r[24]) begin
        e1 = e + 12'sd1;
        if (e1 >= 12'sd255) y = {sign, 8'hFF, 23'b0};
        else y = {sign, e1[7:0], r[23:1]};
      end else begin
        y = {sign, e[7:0], r[22:0]};
      end
    end
    return y;
  endfunction

  function automatic logic fp_is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != '0);
  endfunction

  function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
    logic r;
    if (fp_is_nan(a) || fp_is_nan(b)) r = 1'b0;
    else if ((a[30:0] == '0) && (b[30:0] == '0)) r = 1'b0;
    else if (a[31] != b[31]) r = a[31];
    else if (!a[31]) r = a[30:0] < b[30:0];
    else r = a[30:0] > b[30:0];
    return r;
  endfunction

  function automatic logic fp_eq(input logic [31:0] a, input logic [31:0] b);
    return !fp_is_nan(a) && !fp_is_nan(b) &&
           (((a[30:0] == '0) && (b[30:0] == '0)) || (a == b));
  endfunction

  // tie keeps the first operand
  function automatic logic [31:0] fp_max(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] r;
    if (fp_is_nan(a) || fp_is_nan(b)) r = F_QNAN;
    else r = fp_lt(a, b) ? b : a;
    return r;
  endfunction

  function automatic logic [31:0] fp_min(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] r;
    if (fp_is_nan(a) || fp_is_nan(b)) r = F_QNAN;
    else r = fp_lt(b, a) ? b : a;
    return r;
  endfunction

endpackage

// ----- hdl/sar_fmul.sv -----
// pipelined float32 multiplier: unpack, multiply, normalize and round
module sar_fmul import sar_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] y_o
);

  fp_unp_t     ua, ub;
  fp_side_t    s1_side_d, s1_side_q, s2_side_q;
  logic [23:0] s1_ma_q, s1_mb_q;
  logic [47:0] s2_p_q;
  logic [26:0] m27;
  logic signed [11:0] e_n;
  logic [31:0] y_d, y_q;

  always_comb begin
    ua = fp_unpack(a_i);
    ub = fp_unpack(b_i);
    s1_side_d.sign = ua.sign ^ ub.sign;
    s1_side_d.exp  = ua.exp + ub.exp - 12'sd127;
    s1_side_d.nan  = ua.nan | ub.nan | (ua.inf & ub.zero) | (ua.zero & ub.inf);
    s1_side_d.inf  = ua.inf | ub.inf;
    s1_side_d.zero = ua.zero | ub.zero;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_side_q <= s1_side_d;
      s1_ma_q   <= ua.man;
      s1_mb_q   <= ub.man;
      s2_side_q <= s1_side_q;
      s2_p_q    <= s1_ma_q * s1_mb_q;
      y_q       <= y_d;
    end
  end

  always_comb begin
    if (s2_p_q[47]) begin
      m27 = {s2_p_q[47:22], |s2_p_q[21:0]};
      e_n = s2_side_q.exp + 12'sd1;
    end else begin
      m27 = {s2_p_q[46:21], |s2_p_q[20:0]};
      e_n = s2_side_q.exp;
    end
    if (s2_side_q.nan) y_d = F_QNAN;
    else if (s2_side_q.inf) y_d = {s2_side_q.sign, 8'hFF, 23'b0};
    else if (s2_side_q.zero) y_d = {s2_side_q.sign, 31'b0};
    else y_d = fp_round_pack(s2_side_q.sign, e_n, m27);
  end

  assign y_o = y_q;

endmodule

// ----- hdl/sar_fdiv.sv -----
// pipelined float32 divider: unpack, restoring radix-4 quotient stages, round
module sar_fdiv import sar_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] y_o
);

  fp_unp_t     ua, ub;
  fp_side_t    s1_side_d, s1_side_q;
  logic [23:0] s1_ma_q, s1_mb_q;

  logic [24:0]           r_q    [DIV_STAGES];
  logic [DIV_QBITS-1:0]  q_q    [DIV_STAGES];
  logic [23:0]           mb_q   [DIV_STAGES];
  fp_side_t              side_q [DIV_STAGES];

  fp_side_t    fin_side;
  logic [31:0] y_d, y_q;

  always_comb begin
    ua = fp_unpack(a_i);
    ub = fp_unpack(b_i);
    s1_side_d.sign = ua.sign ^ ub.sign;
    s1_side_d.exp  = ua.exp - ub.exp + 12'sd127;
    s1_side_d.nan  = ua.nan | ub.nan | (ua.zero & ub.zero) | (ua.inf & ub.inf);
    s1_side_d.inf  = ua.inf | ub.zero;
    s1_side_d.zero = ua.zero | ub.inf;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_side_q <= s1_side_d;
      s1_ma_q   <= ua.man;
      s1_mb_q   <= ub.man;
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_iter
    logic [24:0]          r_in, r_d;
    logic [DIV_QBITS-1:0] q_in, q_d;
    logic [23:0]          mb_in;
    fp_side_t             sd_in;

    if (k == 0) begin : g_first
      // prescale so the quotient lands in [1,2)
      always_comb begin
        sd_in = s1_side_q;
        mb_in = s1_mb_q;
        q_in  = '0;
        if (s1_ma_q < s1_mb_q) begin
          r_in      = {s1_ma_q, 1'b0};
          sd_in.exp = s1_side_q.exp - 12'sd1;
        end else begin
          r_in = {1'b0, s1_ma_q};
        end
      end
    end else begin : g_next
      assign r_in  = r_q[k-1];
      assign q_in  = q_q[k-1];
      assign mb_in = mb_q[k-1];
      assign sd_in = side_q[k-1];
    end

    always_comb begin
      r_d = r_in;
      q_d = q_in;
      for (int j = 0; j < DIV_BITS; j++) begin
        if (r_d >= {1'b0, mb_in}) begin
          r_d = r_d - {1'b0, mb_in};
          q_d = {q_d[DIV_QBITS-2:0], 1'b1};
        end else begin
          q_d = {q_d[DIV_QBITS-2:0], 1'b0};
        end
        r_d = {r_d[23:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]    <= r_d;
        q_q[k]    <= q_d;
        mb_q[k]   <= mb_in;
        side_q[k] <= sd_in;
      end
    end
  end

  always_comb begin
    fin_side = side_q[DIV_STAGES-1];
    if (fin_side.nan) y_d = F_QNAN;
    else if (fin_side.inf) y_d = {fin_side.sign, 8'hFF, 23'b0};
    else if (fin_side.zero) y_d = {fin_side.sign, 31'b0};
    else y_d = fp_round_pack(fin_side.sign, fin_side.exp,
                             {q_q[DIV_STAGES-1], |r_q[DIV_STAGES-1]});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) y_q <= y_d;
  end

  assign y_o = y_q;

endmodule

// ----- hdl/sar_fadd.sv -----
// pipelined float32 adder: swap, align, add, normalize, round
module sar_fadd import sar_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] y_o
);

  fp_unp_t     ua, ub, big, sml;
  logic        swap;
  logic        spec_d;
  logic [31:0] spec_val_d;
  logic signed [11:0] dexp;
  logic [4:0]  dsh_d;

  // stage 1
  logic        s1_spec_q, s1_sign_q, s1_sub_q;
  logic [31:0] s1_spec_val_q;
  logic signed [11:0] s1_exp_q;
  logic [23:0] s1_bm_q, s1_sm_q;
  logic [4:0]  s1_dsh_q;
  // stage 2
  logic [26:0] al_se, al_mask, al_sm;
  logic        s2_spec_q, s2_sign_q, s2_sub_q;
  logic [31:0] s2_spec_val_q;
  logic signed [11:0] s2_exp_q;
  logic [26:0] s2_bm_q, s2_sm_q;
  // stage 3
  logic        s3_spec_q, s3_sign_q;
  logic [31:0] s3_spec_val_q;
  logic signed [11:0] s3_exp_q;
  logic [27:0] s3_sum_q;
  // stage 4
  logic [4:0]  lz;
  logic        found;
  logic [26:0] nm_d;
  logic signed [11:0] ne_d;
  logic        s4_spec_q, s4_sign_q, s4_zero_q;
  logic [31:0] s4_spec_val_q;
  logic signed [11:0] s4_exp_q;
  logic [26:0] s4_m_q;
  // stage 5
  logic [31:0] y_d, y_q;

  always_comb begin
    ua   = fp_unpack(a_i);
    ub   = fp_unpack(b_i);
    swap = a_i[30:0] < b_i[30:0];
    big  = swap ? ub : ua;
    sml  = swap ? ua : ub;
    spec_d     = 1'b1;
    spec_val_d = F_QNAN;
    if (ua.nan || ub.nan || (ua.inf && ub.inf && (ua.sign != ub.sign))) spec_val_d = F_QNAN;
    else if (ua.inf) spec_val_d = a_i;
    else if (ub.inf) spec_val_d = b_i;
    else if (ua.zero && ub.zero) spec_val_d = {ua.sign & ub.sign, 31'b0};
    else if (sml.zero) spec_val_d = swap ? b_i : a_i;
    else spec_d = 1'b0;
    dexp  = big.exp - sml.exp;
    dsh_d = (dexp > 12'sd27) ? 5'd27 : dexp[4:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_spec_q     <= spec_d;
      s1_spec_val_q <= spec_val_d;
      s1_sign_q     <= big.sign;
      s1_sub_q      <= ua.sign ^ ub.sign;
      s1_exp_q      <= big.exp;
      s1_bm_q       <= big.man;
      s1_sm_q       <= sml.man;
      s1_dsh_q      <= dsh_d;
    end
  end

  // align the smaller operand, shifted-out bits fold into sticky
  always_comb begin
    al_se   = {s1_sm_q, 3'b0};
    al_mask = ~({27{1'b1}} << s1_dsh_q);
    al_sm   = al_se >> s1_dsh_q;
    al_sm[0] = al_sm[0] | (|(al_se & al_mask));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_spec_q     <= s1_spec_q;
      s2_spec_val_q <= s1_spec_val_q;
      s2_sign_q     <= s1_sign_q;
      s2_sub_q      <= s1_sub_q;
      s2_exp_q      <= s1_exp_q;
      s2_bm_q       <= {s1_bm_q, 3'b0};
      s2_sm_q       <= al_sm;
      s3_spec_q     <= s2_spec_q;
      s3_spec_val_q <= s2_spec_val_q;
      s3_sign_q     <= s2_sign_q;
      s3_exp_q      <= s2_exp_q;
      s3_sum_q      <= s2_sub_q ? ({1'b0, s2_bm_q} - {1'b0, s2_sm_q})
                                : ({1'b0, s2_bm_q} + {1'b0, s2_sm_q});
    end
  end

  always_comb begin
    lz    = '0;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found) begin
        if (s3_sum_q[i]) found = 1'b1;
        else lz = lz + 5'd1;
      end
    end
    if (s3_sum_q[27]) begin
      nm_d = {s3_sum_q[27:2], |s3_sum_q[1:0]};
      ne_d = s3_exp_q + 12'sd1;
    end else begin
      nm_d = s3_sum_q[26:0] << lz;
      ne_d = s3_exp_q - $signed({7'b0, lz});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_spec_q     <= s3_spec_q;
      s4_spec_val_q <= s3_spec_val_q;
      s4_sign_q     <= s3_sign_q;
      s4_zero_q     <= (s3_sum_q == '0);
      s4_exp_q      <= ne_d;
      s4_m_q        <= nm_d;
      y_q           <= y_d;
    end
  end

  // exact cancellation gives plus zero
  always_comb begin
    if (s4_spec_q) y_d = s4_spec_val_q;
    else if (s4_zero_q) y_d = F_ZERO;
    else y_d = fp_round_pack(s4_sign_q, s4_exp_q, s4_m_q);
  end

  assign y_o = y_q;

endmodule

// ----- hdl/saturation_adjustment_rate.sv -----
// top level: condensation rate of the saturation adjustment, float32 pipeline
//
//  channel | handshake                   | payload
//  --------+-----------------------------+---------------------------------------------
//  in      | in_valid_i / in_stall_o     | temperature, vapor, cloud, saturation, latent
//          |                             | heat, heat capacity (float32 each)
//  out     | out_valid_o / out_stall_i   | condensation_rate (float32), complete_evaporation
//  cfg     | cfg_we_i, cfg_addr_i        | cfg_wdata_i (float32 register value)
//
//  one transfer per cycle sustained unless the output stalls with a result held
//  latency is set by the chain of four dividers (13 radix-4 stages each) plus mul/add units
//  reset clears the valid bits and loads the default register values
//  a stall on the output with a result held freezes the whole pipeline in place
module saturation_adjustment_rate import sar_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [31:0]          temperature_i,
  input  logic [31:0]          vapor_ratio_i,
  input  logic [31:0]          cloud_ratio_i,
  input  logic [31:0]          saturation_ratio_i,
  input  logic [31:0]          latent_heat_i,
  input  logic [31:0]          heat_capacity_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [31:0]          condensation_rate_o,
  output logic                 complete_evaporation_o
);

  // delay-line lengths that line up the operands of each unit
  localparam int unsigned D_QS   = MUL_LAT + DIV_LAT;
  localparam int unsigned D_TT   = DIV_LAT + MUL_LAT;
  localparam int unsigned D_DIFF = 2 * MUL_LAT + 2 * DIV_LAT;
  localparam int unsigned D_Q    = 2 * MUL_LAT + 3 * DIV_LAT + ADD_LAT;
  localparam int unsigned N_VLD  = D_Q + DIV_LAT + 2;

  logic en;

  // configuration registers
  logic [31:0] rv_q, qmin_q, dt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q   <= RV_RST;
      qmin_q <= QMIN_RST;
      dt_q   <= DT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_RV:   rv_q   <= cfg_wdata_i;
        CFG_QMIN: qmin_q <= cfg_wdata_i;
        CFG_DT:   dt_q   <= cfg_wdata_i;
        default:  ;
      endcase
    end
  end

  // whole pipeline moves unless a finished result is held by the consumer
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // valid bits travel with the data
  logic vld_q [N_VLD];
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N_VLD; i++) vld_q[i] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < N_VLD; i++) vld_q[i] <= vld_q[i-1];
      out_valid_q <= vld_q[N_VLD-1];
    end
  end

  // entry stage: clamp temperature, vapor floors
  logic [31:0] ts_q, qe_q, qp_q, qc_q, qs_q, xl_q, cpm_q;
  logic [31:0] ts_d;

  always_comb begin
    if (fp_is_nan(temperature_i)) ts_d = temperature_i;
    else if (fp_lt(temperature_i, F_ONE)) ts_d = F_ONE;
    else ts_d = temperature_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ts_q  <= ts_d;
      qe_q  <= fp_max(vapor_ratio_i, qmin_q);
      qp_q  <= fp_max(vapor_ratio_i, F_ZERO);
      qc_q  <= cloud_ratio_i;
      qs_q  <= saturation_ratio_i;
      xl_q  <= latent_heat_i;
      cpm_q <= heat_capacity_i;
    end
  end

  // first products and the vapor excess
  logic [31:0] xl2, rc, tt, diff;

  sar_fmul u_mul_xl2 (.clk_i, .en_i(en), .a_i(xl_q), .b_i(xl_q),  .y_o(xl2));
  sar_fmul u_mul_rc  (.clk_i, .en_i(en), .a_i(rv_q), .b_i(cpm_q), .y_o(rc));
  sar_fmul u_mul_tt  (.clk_i, .en_i(en), .a_i(ts_q), .b_i(ts_q),  .y_o(tt));
  sar_fadd u_add_diff (.clk_i, .en_i(en), .a_i(qe_q), .b_i(qs_q ^ SIGN_MASK), .y_o(diff));

  // operand delay lines
  logic [31:0] qs_dly_q   [D_QS];
  logic [31:0] tt_dly_q   [D_TT];
  logic [31:0] diff_dly_q [D_DIFF];
  logic [31:0] qp_dly_q   [D_Q];
  logic [31:0] qc_dly_q   [D_Q];

  always_ff @(posedge clk_i) begin
    if (en) begin
      qs_dly_q[0]   <= qs_q;
      tt_dly_q[0]   <= tt;
      diff_dly_q[0] <= diff;
      qp_dly_q[0]   <= qp_q;
      qc_dly_q[0]   <= qc_q;
      for (int i = 1; i < D_QS; i++)   qs_dly_q[i]   <= qs_dly_q[i-1];
      for (int i = 1; i < D_TT; i++)   tt_dly_q[i]   <= tt_dly_q[i-1];
      for (int i = 1; i < D_DIFF; i++) diff_dly_q[i] <= diff_dly_q[i-1];
      for (int i = 1; i < D_Q; i++) begin
        qp_dly_q[i] <= qp_dly_q[i-1];
        qc_dly_q[i] <= qc_dly_q[i-1];
      end
    end
  end

  // denom = 1 + ((xl*xl/(rv*cpm))*qs1)/(t*t), work1 = diff/denom
  logic [31:0] tq, term1, term, den, work1;

  sar_fdiv u_div_tq   (.clk_i, .en_i(en), .a_i(xl2), .b_i(rc), .y_o(tq));
  sar_fmul u_mul_term (.clk_i, .en_i(en), .a_i(tq), .b_i(qs_dly_q[D_QS-1]), .y_o(term1));
  sar_fdiv u_div_term (.clk_i, .en_i(en), .a_i(term1), .b_i(tt_dly_q[D_TT-1]), .y_o(term));
  sar_fadd u_add_den  (.clk_i, .en_i(en), .a_i(F_ONE), .b_i(term), .y_o(den));
  sar_fdiv u_div_work (.clk_i, .en_i(en), .a_i(diff_dly_q[D_DIFF-1]), .b_i(den), .y_o(work1));

  // case selection: condense, evaporate or nothing
  logic [31:0] qp_w, qc_w, num_d, num_q, negqc_q;
  logic        cond, evap, zero_q;

  always_comb begin
    qp_w = qp_dly_q[D_Q-1];
    qc_w = qc_dly_q[D_Q-1];
    cond = fp_lt(F_ZERO, work1);
    evap = fp_lt(work1, F_ZERO) && fp_lt(F_ZERO, qc_w);
    num_d = cond ? fp_min(work1, qp_w) : fp_max(work1, qc_w ^ SIGN_MASK);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q   <= num_d;
      zero_q  <= !cond && !evap;
      negqc_q <= qc_w ^ SIGN_MASK;
    end
  end

  // divide by the time step, alongside the complete-evaporation target
  logic [31:0] rate_div, target;
  logic        zero_dly_q [DIV_LAT];

  sar_fdiv u_div_rate (.clk_i, .en_i(en), .a_i(num_q),   .b_i(dt_q), .y_o(rate_div));
  sar_fdiv u_div_tgt  (.clk_i, .en_i(en), .a_i(negqc_q), .b_i(dt_q), .y_o(target));

  always_ff @(posedge clk_i) begin
    if (en) begin
      zero_dly_q[0] <= zero_q;
      for (int i = 1; i < DIV_LAT; i++) zero_dly_q[i] <= zero_dly_q[i-1];
    end
  end

  // output register, nan is canonical
  logic [31:0] rate;
  logic [31:0] out_rate_q;
  logic        out_flag_q;

  assign rate = zero_dly_q[DIV_LAT-1] ? F_ZERO : rate_div;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_rate_q <= fp_is_nan(rate) ? F_QNAN : rate;
      out_flag_q <= fp_eq(rate, target);
    end
  end

  assign out_valid_o            = out_valid_q;
  assign condensation_rate_o    = out_rate_q;
  assign complete_evaporation_o = out_flag_q;

endmodule

// ----- dv/saturation_adjustment_rate_chk.sv -----
// checker for saturation_adjustment_rate: float32 rate predictor and result comparison
module saturation_adjustment_rate_chk import sar_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [31:0]          temperature_i,
  input  logic [31:0]          vapor_ratio_i,
  input  logic [31:0]          cloud_ratio_i,
  input  logic [31:0]          saturation_ratio_i,
  input  logic [31:0]          latent_heat_i,
  input  logic [31:0]          heat_capacity_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [31:0]          condensation_rate_i,
  input  logic                 complete_evaporation_i,
  output int                   errors_o,
  output int                   pending_o,
  output int                   evap_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] rate;
    logic        evap;
  } rate_t;

  rate_t       rate_q[$];
  logic [31:0] gas_const, vapor_min, step_len;

  // float32 pattern to double, exact
  function automatic real to_dbl(logic [31:0] f);
    logic [63:0] d;
    logic [22:0] m;
    int          ue;
    m = f[22:0];
    d = {f[31], 63'b0};
    if (f[30:23] == 8'hFF) d = {f[31], 11'h7FF, m, 29'b0};
    else if (f[30:23] != 8'h00) d = {f[31], 11'(f[30:23] + 11'd896), m, 29'b0};
    else if (m != '0) begin
      ue = -127;
      while (!m[22]) begin
        m  = m << 1;
        ue = ue - 1;
      end
      d = {f[31], 11'(ue + 1023), m[21:0], 30'b0};
    end
    return $bitstoreal(d);
  endfunction

  // double to float32 with round-to-nearest-even, subnormals, canonical nan
  function automatic logic [31:0] to_flt(real x);
    logic [63:0] d, sig, keep, rem, half;
    int          fe, sh;
    d = $realtobits(x);
    if (d[62:52] == 11'h7FF) return (d[51:0] != '0) ? F_QNAN : {d[63], 31'h7F80_0000};
    if (d[62:52] == 11'h000) return {d[63], 31'b0};
    fe  = int'(d[62:52]) - 1023 + 127;
    sig = {11'b0, 1'b1, d[51:0]};
    sh  = 29 + ((fe < 1) ? 1 - fe : 0);
    if (sh > 54) return {d[63], 31'b0};
    keep = sig >> sh;
    rem  = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && keep[0])) keep = keep + 64'd1;
    if (fe < 1) return {d[63], keep[30:0]};
    if (keep[24]) begin
      keep = keep >> 1;
      fe   = fe + 1;
    end
    if (fe >= 255) return {d[63], 31'h7F80_0000};
    return {d[63], 8'(fe), keep[22:0]};
  endfunction

  function automatic logic nan_bits(logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != '0);
  endfunction

  function automatic logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
    return to_flt(to_dbl(a) * to_dbl(b));
  endfunction

  function automatic logic [31:0] f_add(logic [31:0] a, logic [31:0] b);
    return to_flt(to_dbl(a) + to_dbl(b));
  endfunction

  function automatic logic [31:0] f_sub(logic [31:0] a, logic [31:0] b);
    return to_flt(to_dbl(a) - to_dbl(b));
  endfunction

  // zero divisor spelled out, never handed to the simulator
  function automatic logic [31:0] f_div(logic [31:0] a, logic [31:0] b);
    if (b[30:0] == '0) begin
      if (nan_bits(a) || a[30:0] == '0) return F_QNAN;
      return {a[31] ^ b[31], 31'h7F80_0000};
    end
    return to_flt(to_dbl(a) / to_dbl(b));
  endfunction

  function automatic logic f_less(logic [31:0] a, logic [31:0] b);
    return to_dbl(a) < to_dbl(b);
  endfunction

  // tie keeps the first operand
  function automatic logic [31:0] f_hi(logic [31:0] a, logic [31:0] b);
    if (nan_bits(a) || nan_bits(b)) return F_QNAN;
    return f_less(a, b) ? b : a;
  endfunction

  function automatic logic [31:0] f_lo(logic [31:0] a, logic [31:0] b);
    if (nan_bits(a) || nan_bits(b)) return F_QNAN;
    return f_less(b, a) ? b : a;
  endfunction

  function automatic rate_t condensation(logic [31:0] t, logic [31:0] q, logic [31:0] qc,
                                         logic [31:0] qs, logic [31:0] xl, logic [31:0] cp);
    logic [31:0] tc, term, den, work, rate, evap_lvl;
    rate_t       r;
    // temperature clamp passes nan through
    tc   = (!nan_bits(t) && f_less(t, F_ONE)) ? F_ONE : t;
    term = f_div(f_mul(xl, xl), f_mul(gas_const, cp));
    term = f_div(f_mul(term, qs), f_mul(tc, tc));
    den  = f_add(F_ONE, term);
    work = f_div(f_sub(f_hi(q, vapor_min), qs), den);
    if (f_less(F_ZERO, work)) rate = f_div(f_lo(work, f_hi(q, F_ZERO)), step_len);
    else if (f_less(work, F_ZERO) && f_less(F_ZERO, qc))
      rate = f_div(f_hi(work, qc ^ SIGN_MASK), step_len);
    else rate = F_ZERO;
    evap_lvl = f_div(qc ^ SIGN_MASK, step_len);
    r.evap = !nan_bits(rate) && !nan_bits(evap_lvl) && (to_dbl(rate) == to_dbl(evap_lvl));
    r.rate = nan_bits(rate) ? F_QNAN : rate;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rate_t want;
    int    bad;
    bad = 0;
    if (!rst_ni) begin
      gas_const   <= RV_RST;
      vapor_min   <= QMIN_RST;
      step_len    <= DT_RST;
      errors_o    <= 0;
      pending_o   <= 0;
      evap_seen_o <= 0;
      rate_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_RV:   gas_const <= cfg_wdata_i;
          CFG_QMIN: vapor_min <= cfg_wdata_i;
          CFG_DT:   step_len  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        rate_q.push_back(condensation(temperature_i, vapor_ratio_i, cloud_ratio_i,
                                      saturation_ratio_i, latent_heat_i, heat_capacity_i));
      if (out_valid_i && !out_stall_i) begin
        if (rate_q.size() == 0) begin
          $display("%0t: unexpected result rate=%h evap=%b", $time, condensation_rate_i,
                   complete_evaporation_i);
          bad = bad + 1;
        end else begin
          want = rate_q.pop_front();
          if (complete_evaporation_i) evap_seen_o <= evap_seen_o + 1;
          if (want.rate !== condensation_rate_i) begin
            $display("%0t: condensation_rate expected %h actual %h", $time, want.rate,
                     condensation_rate_i);
            bad = bad + 1;
          end
          if (want.evap !== complete_evaporation_i) begin
            $display("%0t: complete_evaporation expected %b actual %b", $time, want.evap,
                     complete_evaporation_i);
            bad = bad + 1;
          end
        end
      end
      errors_o  <= errors_o + bad;
      pending_o <= rate_q.size();
    end
  end
endmodule

// ----- dv/saturation_adjustment_rate_tb.sv -----
// testbench top for saturation_adjustment_rate: stimulus, stall pressure and verdict
module saturation_adjustment_rate_tb import sar_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 3000;
  localparam int SETTLE_CYCLES   = 100;  // a bit over the pipeline depth
  localparam int HOLD_CYCLES     = 300;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr_i = CFG_RV;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [31:0]          temperature_i = '0;
  logic [31:0]          vapor_ratio_i = '0;
  logic [31:0]          cloud_ratio_i = '0;
  logic [31:0]          saturation_ratio_i = '0;
  logic [31:0]          latent_heat_i = '0;
  logic [31:0]          heat_capacity_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [31:0]          condensation_rate_o;
  logic                 complete_evaporation_o;

  int errors, pending, evap_seen;
  int cells_sent = 0;
  int cfg_sets = 0;
  bit sink_quiet = 1'b0;  // no random output stalls while set
  bit sink_hold = 1'b0;   // request a long output hold-off
  bit src_quiet = 1'b0;   // no random input gaps while set

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  saturation_adjustment_rate dut (.*);

  saturation_adjustment_rate_chk chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o),
    .temperature_i, .vapor_ratio_i, .cloud_ratio_i, .saturation_ratio_i,
    .latent_heat_i, .heat_capacity_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .condensation_rate_i(condensation_rate_o),
    .complete_evaporation_i(complete_evaporation_o),
    .errors_o(errors), .pending_o(pending), .evap_seen_o(evap_seen)
  );

  // double to float32 by the checker's rounding, only for building stimulus values
  function automatic logic [31:0] flt(real x);
    return chk.to_flt(x);
  endfunction

  // watchdog: cycles without any transfer or register write
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("timeout after %0d idle cycles, %0d results outstanding", quiet_cycles,
                 pending);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // output side: random stalls, a long hold-off on request
  initial begin
    forever begin
      if (sink_hold) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        sink_hold = 1'b0;
      end else begin
        out_stall_i <= !sink_quiet && ($urandom_range(99) < 11);
        @(posedge clk_i);
      end
    end
  end

  // one transfer; valid stays high into the next item unless a gap follows
  task automatic send_cell(logic [31:0] t, logic [31:0] q, logic [31:0] qc, logic [31:0] qs,
                           logic [31:0] xl, logic [31:0] cp);
    if (!src_quiet && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    temperature_i      <= t;
    vapor_ratio_i      <= q;
    cloud_ratio_i      <= qc;
    saturation_ratio_i <= qs;
    latent_heat_i      <= xl;
    heat_capacity_i    <= cp;
    do @(posedge clk_i); while (in_stall_o);
    cells_sent++;
  endtask

  // drop valid and wait for every expected result, then let the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [31:0] rv, logic [31:0] qmin, logic [31:0] dt);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_RV;
    cfg_wdata_i <= rv;
    @(posedge clk_i);
    cfg_addr_i  <= CFG_QMIN;
    cfg_wdata_i <= qmin;
    @(posedge clk_i);
    cfg_addr_i  <= CFG_DT;
    cfg_wdata_i <= dt;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cfg_sets++;
  endtask

  function automatic logic [31:0] odd_value();
    case ($urandom_range(11))
      0:  return 32'h0000_0000;
      1:  return 32'h8000_0000;
      2:  return 32'h7F80_0000;
      3:  return 32'hFF80_0000;
      4:  return 32'h7FC0_0000;
      5:  return 32'h0000_0001;
      6:  return 32'h7F7F_FFFF;
      7:  return 32'h3F80_0000;
      8:  return 32'h007F_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // mostly physically sensible cells, with some raw bit patterns and odd values
  task automatic random_cell();
    logic [31:0] f[6];
    int          pick;
    pick = $urandom_range(99);
    if (pick < 65) begin
      f[0] = flt(180.0 + $urandom_range(15000) / 100.0);
      f[1] = flt($urandom_range(25000) / 1.0e6);
      f[3] = flt($urandom_range(25000) / 1.0e6);
      // cloud water: often none, sometimes just a trace so it all evaporates
      case ($urandom_range(3))
        0:       f[2] = 32'h0000_0000;
        1:       f[2] = flt($urandom_range(1, 50) / 1.0e7);
        default: f[2] = flt($urandom_range(3000) / 1.0e6);
      endcase
      f[4] = flt(2.4e6 + $urandom_range(200000));
      f[5] = flt(1000.0 + $urandom_range(20000) / 1000.0);
    end else if (pick < 85) begin
      foreach (f[i]) f[i] = $urandom();
    end else begin
      foreach (f[i]) f[i] = ($urandom_range(1)) ? odd_value() : $urandom();
    end
    send_cell(f[0], f[1], f[2], f[3], f[4], f[5]);
  endtask

  initial begin
    logic [31:0] xl_n, cp_n;
    xl_n = 32'h4A18_9A80;  // about 2.5e6
    cp_n = 32'h447B_0000;  // 1004.0
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed cells at reset register values
    src_quiet = 1'b1;
    send_cell(32'h4392_0000, 32'h3C23_D70A, 32'h0000_0000, 32'h3BA3_D70A, xl_n, cp_n);
    // subsaturated with a trace of cloud water: evaporates it all
    send_cell(32'h4392_0000, 32'h3BA3_D70A, 32'h3727_C5AC, 32'h3C23_D70A, xl_n, cp_n);
    // subsaturated with plenty of cloud water: partial evaporation
    send_cell(32'h4392_0000, 32'h3BA3_D70A, 32'h3C23_D70A, 32'h3C23_D70A, xl_n, cp_n);
    // subsaturated, no cloud: zero rate
    send_cell(32'h4392_0000, 32'h3BA3_D70A, 32'h0000_0000, 32'h3C23_D70A, xl_n, cp_n);
    // negative zero cloud water
    send_cell(32'h4392_0000, 32'h3BA3_D70A, 32'h8000_0000, 32'h3C23_D70A, xl_n, cp_n);
    // negative vapor lifted to the floor
    send_cell(32'h4392_0000, 32'hBC23_D70A, 32'h3A83_126F, 32'h3BA3_D70A, xl_n, cp_n);
    // temperature clamp: zero, subnormal, below one, nan
    send_cell(32'h0000_0000, 32'h3C23_D70A, 32'h0000_0000, 32'h3BA3_D70A, xl_n, cp_n);
    send_cell(32'h0000_0001, 32'h3C23_D70A, 32'h3A83_126F, 32'h3BA3_D70A, xl_n, cp_n);
    send_cell(32'h3F00_0000, 32'h3BA3_D70A, 32'h3A83_126F, 32'h3C23_D70A, xl_n, cp_n);
    send_cell(32'h7FC0_0001, 32'h3C23_D70A, 32'h3A83_126F, 32'h3BA3_D70A, xl_n, cp_n);
    // nan saturation ratio: nan work term, zero rate
    send_cell(32'h4392_0000, 32'h3C23_D70A, 32'h3A83_126F, 32'hFFFF_FFFF, xl_n, cp_n);
    // zero heat capacity and zero latent heat: division by zero paths
    send_cell(32'h4392_0000, 32'h3C23_D70A, 32'h3A83_126F, 32'h3BA3_D70A, xl_n, 32'h0);
    send_cell(32'h4392_0000, 32'h3C23_D70A, 32'h3A83_126F, 32'h3BA3_D70A, 32'h0, 32'h0);
    // infinities and field extremes
    send_cell(32'h7F80_0000, 32'h7F80_0000, 32'h7F80_0000, 32'h7F80_0000, 32'hFF80_0000,
              32'h7F80_0000);
    send_cell(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h0000_0001, 32'h7F7F_FFFF,
              32'h0000_0001);
    send_cell(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);
    send_cell(32'h4392_0000, 32'h0000_0001, 32'h0000_0001, 32'h8000_0001, xl_n, cp_n);
    drain();

    // random cells, with a long output hold-off partway while input keeps coming
    src_quiet = 1'b0;
    for (int i = 0; i < 180; i++) begin
      if (i == 60) sink_hold = 1'b1;
      random_cell();
    end
    // stretch without any idling on either side
    sink_quiet = 1'b1;
    src_quiet  = 1'b1;
    for (int i = 0; i < 100; i++) random_cell();
    sink_quiet = 1'b0;
    src_quiet  = 1'b0;
    drain();

    // register extremes and other settings, random cells under each
    set_regs(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    for (int i = 0; i < 70; i++) random_cell();
    drain();
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 60; i++) random_cell();
    drain();
    set_regs(32'h7F7F_FFFF, 32'h8000_0001, 32'h0000_0001);
    for (int i = 0; i < 60; i++) random_cell();
    drain();
    set_regs(RV_RST, 32'h0000_0000, 32'h4120_0000);
    for (int i = 0; i < 70; i++) random_cell();
    drain();
    set_regs($urandom(), $urandom(), $urandom());
    for (int i = 0; i < 40; i++) random_cell();
    drain();
    set_regs(32'h43E8_0000, QMIN_RST, 32'h4270_0000);
    for (int i = 0; i < 100; i++) begin
      if (i == 50) sink_hold = 1'b1;
      random_cell();
    end
    drain();

    $display("covered %0d cells under %0d register settings plus reset values,", cells_sent,
             cfg_sets);
    $display("including output hold-offs and %0d complete evaporations", evap_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
